>>> design/rcp_pkg.sv
// Package for the command parser: byte codes, result kinds, error codes,
// parser phase type and the inter-stage struct. No dependencies.
package rcp_pkg;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [1:0] KIND_PAYLOAD     = 2'd0;
   localparam logic [1:0] KIND_EMPTY_STR   = 2'd1;
   localparam logic [1:0] KIND_EMPTY_ARRAY = 2'd2;
   localparam logic [1:0] KIND_ERROR       = 2'd3;

   localparam logic [2:0] ERR_NO_STAR    = 3'd0;
   localparam logic [2:0] ERR_NO_DOLLAR  = 3'd1;
   localparam logic [2:0] ERR_BAD_DIGIT  = 3'd2;
   localparam logic [2:0] ERR_COUNT_BIG  = 3'd3;
   localparam logic [2:0] ERR_LENGTH_BIG = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_RESYNC     = 4'd1,
      PH_COUNT      = 4'd2,
      PH_SKIP_COUNT = 4'd3,
      PH_DOLLAR     = 4'd4,
      PH_LEN        = 4'd5,
      PH_SKIP_LEN   = 4'd6,
      PH_PAYLOAD    = 4'd7,
      PH_TRAIL1     = 4'd8,
      PH_TRAIL2     = 4'd9
   } phase_type;

   // Held byte handed from the input register to the parser
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } stage_type;

endpackage

>>> design/rcp_req_if.sv
// Input channel interface: valid/ready handshake carrying one stream byte.
// Depends on nothing.
interface rcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

>>> design/rcp_rsp_if.sv
// Result channel interface: valid/ready handshake carrying one parser result.
// Depends on nothing.
interface rcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [7:0]  element_index;
   logic [15:0] element_length;
   logic        last_in_element;
   logic        last_in_command;
   logic [2:0]  error_code;

   modport source (output valid, output kind, output payload_byte, output element_index,
                   output element_length, output last_in_element, output last_in_command,
                   output error_code, input ready);
   modport sink   (input valid, input kind, input payload_byte, input element_index,
                   input element_length, input last_in_element, input last_in_command,
                   input error_code, output ready);
endinterface

>>> design/resp_command_parser.sv
// Top level of the command parser: input register feeding the parser core.
// Depends on rcp_pkg, rcp_req_if, rcp_rsp_if, rcp_input_stage, rcp_parse_core.
//
// Parses a byte stream holding arrays of bulk strings and gives one result per payload
// byte, per empty string or empty array, and per format error; after an error it drops
// bytes until the next '*'. It takes one byte every clock cycle unless stalled. A byte is captured
// by the input register and parsed from there into the result register once that register is
// empty or its result is being transferred. Input stalls only while the input register holds a
// byte and the result register holds a result that has not yet been transferred.
module resp_command_parser
   import rcp_pkg::*;
#(
   parameter int MAX_ELEMENTS      = 255,
   parameter int MAX_STRING_LENGTH = 65535
) (
   input  logic      clock,
   input  logic      reset,
   rcp_req_if.sink   req_ch,
   rcp_rsp_if.source rsp_ch
);

   stage_type stage;
   logic      advance;

   rcp_input_stage u_input (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   rcp_parse_core #(
      .MAX_ELEMENTS      (MAX_ELEMENTS),
      .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .rsp     (rsp_ch)
   );

endmodule

>>> design/rcp_input_stage.sv
// Input register of the command parser: captures one byte per transfer.
// Depends on rcp_pkg and rcp_req_if.
module rcp_input_stage
   import rcp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rcp_req_if.sink   req,
   input  logic      advance,
   output stage_type stage
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req.stream_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

>>> design/rcp_parse_core.sv
// Parser state machine and result register of the command parser.
// Depends on rcp_pkg and rcp_rsp_if.
module rcp_parse_core
   import rcp_pkg::*;
#(
   parameter int MAX_ELEMENTS      = 255,
   parameter int MAX_STRING_LENGTH = 65535
) (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage,
   output logic      advance,
   rcp_rsp_if.source rsp
);

   localparam int EW = $clog2(MAX_ELEMENTS + 1);
   localparam int LW = $clog2(MAX_STRING_LENGTH + 1);
   localparam int AW = (EW > LW) ? EW : LW;
   localparam int VW = AW + 4;
   localparam logic [VW-1:0] COUNT_LIMIT  = VW'(MAX_ELEMENTS);
   localparam logic [VW-1:0] LENGTH_LIMIT = VW'(MAX_STRING_LENGTH);

   phase_type   phase_ff, phase_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [EW-1:0] left_ff, left_in;
   logic [EW-1:0] cur_ff, cur_in;
   logic [LW-1:0] slen_ff, slen_in;
   logic [LW-1:0] bleft_ff, bleft_in;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  index_ff, index_in;
   logic [15:0] length_ff, length_in;
   logic        lel_ff, lel_in;
   logic        lcmd_ff, lcmd_in;
   logic [2:0]  err_ff, err_in;
   logic        emit;

   logic [7:0]    b;
   logic          is_digit;
   logic [3:0]    digit;
   logic [VW-1:0] acc_wide, acc_next;
   logic          acc_zero;
   logic [LW-1:0] bleft_dec;
   logic [EW-1:0] left_dec;
   logic          last_elem;

   assign advance = stage.valid && (!valid_ff || rsp.ready);

   assign b         = stage.data;
   assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
   assign digit     = 4'(b - CH_ZERO);
   assign acc_wide  = VW'(acc_ff);
   assign acc_next  = (acc_wide << 3) + (acc_wide << 1) + VW'(digit);
   assign acc_zero  = (acc_ff == '0);
   assign bleft_dec = (bleft_ff != '0) ? bleft_ff - LW'(1) : bleft_ff;
   assign left_dec  = (left_ff != '0) ? left_ff - EW'(1) : left_ff;
   assign last_elem = (left_ff == EW'(1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_RESYNC: begin
               if (b == CH_STAR) phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               if (b == CH_CR) phase_in = PH_SKIP_COUNT;
               else if (!is_digit || acc_next > COUNT_LIMIT) phase_in = PH_RESYNC;
            end
            PH_SKIP_COUNT: phase_in = (left_ff == '0) ? PH_IDLE : PH_DOLLAR;
            PH_DOLLAR:     phase_in = (b == CH_DOLLAR) ? PH_LEN : PH_RESYNC;
            PH_LEN: begin
               if (b == CH_CR) phase_in = PH_SKIP_LEN;
               else if (!is_digit || acc_next > LENGTH_LIMIT) phase_in = PH_RESYNC;
            end
            PH_SKIP_LEN: phase_in = (bleft_ff == '0) ? PH_TRAIL1 : PH_PAYLOAD;
            PH_PAYLOAD: begin
               if (bleft_dec == '0) phase_in = PH_TRAIL1;
            end
            PH_TRAIL1: phase_in = PH_TRAIL2;
            PH_TRAIL2: phase_in = (left_dec == '0) ? PH_IDLE : PH_DOLLAR;
            default:   phase_in = (b == CH_STAR) ? PH_COUNT : PH_RESYNC;
         endcase
      end
   end

   // counters and result
   always_comb begin
      acc_in    = acc_ff;
      left_in   = left_ff;
      cur_in    = cur_ff;
      slen_in   = slen_ff;
      bleft_in  = bleft_ff;
      emit      = 1'b0;
      kind_in   = KIND_ERROR;
      byte_in   = '0;
      index_in  = '0;
      length_in = '0;
      lel_in    = 1'b0;
      lcmd_in   = 1'b0;
      err_in    = ERR_NO_STAR;
      if (advance) begin
         unique case (phase_ff)
            PH_RESYNC: begin
               if (b == CH_STAR) acc_in = '0;
            end
            PH_COUNT: begin
               if (b == CH_CR) begin
                  left_in = EW'(acc_ff);
                  cur_in  = '0;
                  acc_in  = '0;
                  if (acc_zero) begin
                     emit    = 1'b1;
                     kind_in = KIND_EMPTY_ARRAY;
                     lcmd_in = 1'b1;
                  end
               end else if (!is_digit) begin
                  emit   = 1'b1;
                  err_in = ERR_BAD_DIGIT;
                  acc_in = '0;
               end else if (acc_next > COUNT_LIMIT) begin
                  emit   = 1'b1;
                  err_in = ERR_COUNT_BIG;
                  acc_in = '0;
               end else begin
                  acc_in = AW'(acc_next);
               end
            end
            PH_SKIP_COUNT: ;
            PH_DOLLAR: begin
               acc_in = '0;
               if (b != CH_DOLLAR) begin
                  emit   = 1'b1;
                  err_in = ERR_NO_DOLLAR;
               end
            end
            PH_LEN: begin
               if (b == CH_CR) begin
                  slen_in  = LW'(acc_ff);
                  bleft_in = LW'(acc_ff);
                  acc_in   = '0;
                  if (acc_zero) begin
                     emit     = 1'b1;
                     kind_in  = KIND_EMPTY_STR;
                     index_in = 8'(cur_ff);
                     lel_in   = 1'b1;
                     lcmd_in  = last_elem;
                  end
               end else if (!is_digit) begin
                  emit   = 1'b1;
                  err_in = ERR_BAD_DIGIT;
                  acc_in = '0;
               end else if (acc_next > LENGTH_LIMIT) begin
                  emit   = 1'b1;
                  err_in = ERR_LENGTH_BIG;
                  acc_in = '0;
               end else begin
                  acc_in = AW'(acc_next);
               end
            end
            PH_SKIP_LEN: ;
            PH_PAYLOAD: begin
               bleft_in  = bleft_dec;
               emit      = 1'b1;
               kind_in   = KIND_PAYLOAD;
               byte_in   = b;
               index_in  = 8'(cur_ff);
               length_in = 16'(slen_ff);
               lel_in    = (bleft_dec == '0);
               lcmd_in   = (bleft_dec == '0) && last_elem;
            end
            PH_TRAIL1: ;
            PH_TRAIL2: begin
               left_in = left_dec;
               cur_in  = cur_ff + EW'(1);
            end
            default: begin
               acc_in = '0;
               // stray byte while waiting for a command
               if (b != CH_STAR) emit = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = emit;
      else if (rsp.ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         left_ff  <= '0;
         cur_ff   <= '0;
         slen_ff  <= '0;
         bleft_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         cur_ff   <= cur_in;
         slen_ff  <= slen_in;
         bleft_ff <= bleft_in;
         valid_ff <= valid_in;
      end
      if (advance && emit) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         index_ff  <= index_in;
         length_ff <= length_in;
         lel_ff    <= lel_in;
         lcmd_ff   <= lcmd_in;
         err_ff    <= err_in;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.kind            = kind_ff;
   assign rsp.payload_byte    = byte_ff;
   assign rsp.element_index   = index_ff;
   assign rsp.element_length  = length_ff;
   assign rsp.last_in_element = lel_ff;
   assign rsp.last_in_command = lcmd_ff;
   assign rsp.error_code      = err_ff;

endmodule

>>> tb/rcp_result_checker.sv
// Result checker for the command parser: follows both channels, predicts the
// parser results and compares them in order. Depends on rcp_pkg, rcp_req_if, rcp_rsp_if.
`timescale 1ns / 1ps
module rcp_result_checker
   import rcp_pkg::*;
#(
   parameter int MAX_ELEMENTS      = 255,
   parameter int MAX_STRING_LENGTH = 65535
) (
   input  logic clock,
   input  logic reset,
   rcp_req_if   req_ch,
   rcp_rsp_if   rsp_ch,
   output int   fail_count,
   output int   outstanding,
   output int   payload_seen,
   output int   marker_seen,
   output int   error_seen
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [7:0]  element_index;
      logic [15:0] element_length;
      logic        last_in_element;
      logic        last_in_command;
      logic [2:0]  error_code;
   } token_t;

   phase_type   ph;
   int unsigned acc;
   int unsigned elems_left;
   int unsigned cur_elem;
   int unsigned str_len;
   int unsigned bytes_left;
   token_t      awaited_tokens[$];

   // Format fault: parser drops everything up to the next '*'
   function automatic token_t raise_fault(input logic [2:0] code);
      token_t t;
      t = '0;
      t.kind = KIND_ERROR;
      t.error_code = code;
      ph = PH_RESYNC;
      acc = 0;
      return t;
   endfunction

   task automatic parse_byte(input logic [7:0] b, output bit produced, output token_t t);
      int unsigned v;
      int unsigned lim;
      bit          last;
      produced = 1'b0;
      t = '0;
      case (ph)
         PH_RESYNC: begin
            if (b == CH_STAR) begin
               acc = 0;
               ph = PH_COUNT;
            end
         end
         PH_COUNT, PH_LEN: begin
            lim = (ph == PH_COUNT) ? MAX_ELEMENTS : MAX_STRING_LENGTH;
            if (b == CH_CR) begin
               if (ph == PH_COUNT) begin
                  elems_left = acc;
                  cur_elem = 0;
                  ph = PH_SKIP_COUNT;
                  if (acc == 0) begin
                     produced = 1'b1;
                     t.kind = KIND_EMPTY_ARRAY;
                     t.last_in_command = 1'b1;
                  end
               end else begin
                  str_len = acc;
                  bytes_left = acc;
                  ph = PH_SKIP_LEN;
                  if (acc == 0) begin
                     produced = 1'b1;
                     t.kind = KIND_EMPTY_STR;
                     t.element_index = cur_elem[7:0];
                     t.last_in_element = 1'b1;
                     t.last_in_command = (elems_left == 1);
                  end
               end
               acc = 0;
            end else if (b < CH_ZERO || b > CH_NINE) begin
               produced = 1'b1;
               t = raise_fault(ERR_BAD_DIGIT);
            end else begin
               v = acc * 10 + (b - CH_ZERO);
               if (v > lim) begin
                  produced = 1'b1;
                  t = raise_fault((ph == PH_COUNT) ? ERR_COUNT_BIG : ERR_LENGTH_BIG);
               end else begin
                  acc = v;
               end
            end
         end
         PH_SKIP_COUNT: ph = (elems_left == 0) ? PH_IDLE : PH_DOLLAR;
         PH_DOLLAR: begin
            if (b != CH_DOLLAR) begin
               produced = 1'b1;
               t = raise_fault(ERR_NO_DOLLAR);
            end else begin
               acc = 0;
               ph = PH_LEN;
            end
         end
         PH_SKIP_LEN: ph = (bytes_left == 0) ? PH_TRAIL1 : PH_PAYLOAD;
         PH_PAYLOAD: begin
            if (bytes_left > 0) bytes_left--;
            last = (bytes_left == 0);
            if (last) ph = PH_TRAIL1;
            produced = 1'b1;
            t.kind = KIND_PAYLOAD;
            t.payload_byte = b;
            t.element_index = cur_elem[7:0];
            t.element_length = str_len[15:0];
            t.last_in_element = last;
            t.last_in_command = last && (elems_left == 1);
         end
         PH_TRAIL1: ph = PH_TRAIL2;
         PH_TRAIL2: begin
            if (elems_left > 0) elems_left--;
            cur_elem++;
            ph = (elems_left == 0) ? PH_IDLE : PH_DOLLAR;
         end
         default: begin
            // waiting for a command: anything but '*' is complained about once
            if (b == CH_STAR) begin
               acc = 0;
               ph = PH_COUNT;
            end else begin
               produced = 1'b1;
               t = raise_fault(ERR_NO_STAR);
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got, inout bit bad);
      if (want !== got) begin
         bad = 1'b1;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      bit     produced;
      bit     bad;
      token_t want;
      token_t seen;
      if (reset) begin
         ph = PH_IDLE;
         acc = 0;
         elems_left = 0;
         cur_elem = 0;
         str_len = 0;
         bytes_left = 0;
         awaited_tokens.delete();
         fail_count = 0;
         payload_seen = 0;
         marker_seen = 0;
         error_seen = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            parse_byte(req_ch.stream_byte, produced, want);
            if (produced) awaited_tokens.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.kind = rsp_ch.kind;
            seen.payload_byte = rsp_ch.payload_byte;
            seen.element_index = rsp_ch.element_index;
            seen.element_length = rsp_ch.element_length;
            seen.last_in_element = rsp_ch.last_in_element;
            seen.last_in_command = rsp_ch.last_in_command;
            seen.error_code = rsp_ch.error_code;
            case (seen.kind)
               KIND_PAYLOAD: payload_seen++;
               KIND_ERROR:   error_seen++;
               default:      marker_seen++;
            endcase
            if (awaited_tokens.size() == 0) begin
               $display("%0t: result with nothing expected, got kind %0d code %0d",
                        $time, seen.kind, seen.error_code);
               fail_count++;
            end else begin
               want = awaited_tokens.pop_front();
               bad = 1'b0;
               compare_field("kind", want.kind, seen.kind, bad);
               compare_field("payload_byte", want.payload_byte, seen.payload_byte, bad);
               compare_field("element_index", want.element_index, seen.element_index, bad);
               compare_field("element_length", want.element_length, seen.element_length,
                             bad);
               compare_field("last_in_element", want.last_in_element, seen.last_in_element,
                             bad);
               compare_field("last_in_command", want.last_in_command, seen.last_in_command,
                             bad);
               compare_field("error_code", want.error_code, seen.error_code, bad);
               if (bad) fail_count++;
            end
         end
      end
      outstanding <= awaited_tokens.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the command parser testbench: clock, reset, byte stimulus and result
// back-pressure, verdict. Depends on rcp_pkg, both channel interfaces, rcp_result_checker.
`timescale 1ns / 1ps
module tb_top
   import rcp_pkg::*;
();

   localparam int MAX_ELEMENTS      = 255;
   localparam int MAX_STRING_LENGTH = 65535;
   localparam int RANDOM_BYTES      = 1300;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int DRAIN_CYCLES      = 8;
   localparam logic [7:0] LF        = 8'h0A;

   logic clock;
   logic reset;

   rcp_req_if req_bus ();
   rcp_rsp_if rsp_bus ();

   int fail_count;
   int outstanding;
   int payload_seen;
   int marker_seen;
   int error_seen;

   bit         quiet = 1'b0;
   int         bytes_sent = 0;
   int         commands_built = 0;
   int         idle_cycles = 0;
   logic [7:0] cmd_q[$];

   resp_command_parser #(
      .MAX_ELEMENTS      (MAX_ELEMENTS),
      .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   rcp_result_checker #(
      .MAX_ELEMENTS      (MAX_ELEMENTS),
      .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
   ) token_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_bus),
      .rsp_ch       (rsp_bus),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .payload_seen (payload_seen),
      .marker_seen  (marker_seen),
      .error_seen   (error_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] filler(input logic [7:0] usual);
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : usual;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.stream_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // '|' stands for CR in directed text
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte((s[i] == "|") ? CH_CR : s[i]);
   endtask

   task automatic send_queued();
      while (cmd_q.size() > 0) send_byte(cmd_q.pop_front());
   endtask

   task automatic add_number(input int unsigned value);
      string digits;
      digits = $sformatf("%0d", value);
      if (value == 0 && $urandom_range(0, 3) == 0) return;
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) cmd_q.push_back(CH_ZERO);
      for (int i = 0; i < digits.len(); i++) cmd_q.push_back(digits[i]);
   endtask

   task automatic build_command(input int n_elem, input int min_len, input int max_len);
      int len;
      cmd_q.push_back(CH_STAR);
      add_number(n_elem);
      cmd_q.push_back(CH_CR);
      cmd_q.push_back(filler(LF));
      for (int e = 0; e < n_elem; e++) begin
         len = (min_len == 0 && $urandom_range(0, 5) == 0) ? 0 :
               $urandom_range((min_len > 0) ? min_len : 1, max_len);
         cmd_q.push_back(CH_DOLLAR);
         add_number(len);
         cmd_q.push_back(CH_CR);
         cmd_q.push_back(filler(LF));
         repeat (len) cmd_q.push_back(8'($urandom_range(0, 255)));
         cmd_q.push_back(filler(CH_CR));
         cmd_q.push_back(filler(LF));
      end
      commands_built++;
   endtask

   // result side back-pressure
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int r;
      int idx;
      int start;
      req_bus.valid <= 1'b0;
      req_bus.stream_byte <= 8'h00;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // garbage while idle, then dropped while resyncing
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("*0|.");
      send_text("*|.");
      send_text("*1|.$0|...");
      send_text("*2|.$1|.A..$|...");
      send_text("*1|.$2|.");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("..");
      send_text("*1|.#");
      send_text("*1/");
      send_text("*:");
      send_text("*256");
      send_text("*1|.$65536");

      // widest count and longest length accepted; parser is resyncing, so '*' starts each
      send_text("*255|.$65535#");
      send_text("*255|.$0|...$1|.Z..!");

      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         quiet = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 99);
         if (r < 65) begin
            build_command(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4), 0,
                          ($urandom_range(0, 9) == 0) ? 40 : 8);
         end else if (r < 80) begin
            build_command($urandom_range(1, 3), 0, 8);
            idx = $urandom_range(0, cmd_q.size() - 1);
            cmd_q[idx] = 8'($urandom_range(0, 255));
         end else if (r < 90) begin
            repeat ($urandom_range(1, 4)) cmd_q.push_back(8'($urandom_range(0, 255)));
         end else if (r < 95) begin
            cmd_q.push_back(CH_STAR);
            add_number(($urandom_range(0, 1) == 1) ? MAX_ELEMENTS + 1 :
                       $urandom_range(MAX_ELEMENTS + 1, 99999));
         end else begin
            cmd_q.push_back(CH_STAR);
            add_number(1);
            cmd_q.push_back(CH_CR);
            cmd_q.push_back(LF);
            cmd_q.push_back(CH_DOLLAR);
            add_number(($urandom_range(0, 1) == 1) ? MAX_STRING_LENGTH + 1 :
                       $urandom_range(MAX_STRING_LENGTH + 1, 9999999));
         end
         send_queued();
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d stream bytes, %0d generated commands plus directed cases",
               bytes_sent, commands_built);
      $display("Results checked: %0d payload bytes, %0d empty markers, %0d format errors",
               payload_seen, marker_seen, error_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         if (outstanding != 0)
            $display("%0t: %0d expected results never arrived", $time, outstanding);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
